>>> rtl/median_then_moving_average_unit_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros used by the median / moving average RTL
// ----------------------------------------------------------------------------
`ifndef MEDIAN_THEN_MOVING_AVERAGE_UNIT_ASSERT_SVH
`define MEDIAN_THEN_MOVING_AVERAGE_UNIT_ASSERT_SVH

// same-cycle implication
`define MTMA_ASSERT_IMP(lbl, clk_s, rst_n_s, ante, cons) \
	lbl: assert property (@(posedge clk_s) disable iff (!rst_n_s) (ante) |-> (cons)) \
		else $error("implication check failed");

// next-cycle implication
`define MTMA_ASSERT_NXT(lbl, clk_s, rst_n_s, ante, cons) \
	lbl: assert property (@(posedge clk_s) disable iff (!rst_n_s) (ante) |=> (cons)) \
		else $error("next-cycle check failed");

`endif

>>> rtl/mtma_pkg.sv
// ----------------------------------------------------------------------------
// mtma_pkg
// Types, constants and helpers of the median / moving average unit.
// ----------------------------------------------------------------------------
package mtma_pkg;

	localparam int MED_DEPTH = 11;
	localparam int AVG_DEPTH = 11;
	localparam int SAMPLE_W  = 16;
	localparam int LEN_W     = 4;
	localparam int SUM_W     = 21;
	localparam int CFG_IDX_W = 2;
	localparam int MIDX_W    = $clog2(MED_DEPTH);
	localparam int AIDX_W    = $clog2(AVG_DEPTH);
	localparam int CNT_W     = $clog2(MED_DEPTH + 1);
	localparam int DCNT_W    = $clog2(SUM_W);

	typedef logic signed [SAMPLE_W-1:0] sample_t;
	typedef logic signed [SUM_W-1:0]    sum_t;
	typedef logic [LEN_W-1:0]           len_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_MED_LEN = 2'd0,
		REG_AVG_LEN = 2'd1,
		REG_START   = 2'd2
	} reg_idx_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MEDIAN,
		ST_UPDATE,
		ST_LOAD,
		ST_DIVIDE,
		ST_FINISH
	} state_t;

	localparam int      RST_MED_LEN_I = 5;
	localparam int      RST_AVG_LEN_I = 4;
	localparam int      RST_START_I   = 400;  // 25.0 in Q12.4
	localparam len_t    RST_MED_LEN   = LEN_W'(RST_MED_LEN_I);
	localparam len_t    RST_AVG_LEN   = LEN_W'(RST_AVG_LEN_I);
	localparam sample_t RST_START     = SAMPLE_W'(RST_START_I);
	localparam sum_t    RST_SUM       = SUM_W'(RST_START_I * RST_AVG_LEN_I);

	// odd length in 1..MED_DEPTH
	function automatic len_t eff_med_len(input len_t r);
		len_t n;
		n = r;
		if (n == '0) n = LEN_W'(1);
		if (n > LEN_W'(MED_DEPTH)) n = LEN_W'(MED_DEPTH);
		if (!n[0]) n = n - LEN_W'(1);
		if (n == '0) n = LEN_W'(1);
		return n;
	endfunction

	function automatic len_t eff_avg_len(input len_t r);
		len_t n;
		n = r;
		if (n == '0) n = LEN_W'(1);
		if (n > LEN_W'(AVG_DEPTH)) n = LEN_W'(AVG_DEPTH);
		return n;
	endfunction

	function automatic sum_t start_sum(input sample_t s, input len_t a);
		sum_t sx;
		sum_t ax;
		sx = SUM_W'(s);
		ax = sum_t'({{(SUM_W-LEN_W){1'b0}}, a});
		return sx * ax;
	endfunction

endpackage

>>> rtl/median_then_moving_average_unit.sv
// ----------------------------------------------------------------------------
// median_then_moving_average_unit
// Sliding median of the last samples, followed by a moving average of the
// medians, signed Q12.4.
// ----------------------------------------------------------------------------
// Usage:
//   Input beat (in_valid/in_ready, sample) is one Q12.4 sample. Each input
//   beat yields exactly one output beat (out_valid/out_ready, smoothed).
//   Configuration beats (cfg_valid/cfg_ready, cfg_index, cfg_data) write
//   median length (0), average length (1) and start value (2); a write to
//   either length refills both windows with the start value.
//   cfg_ready and in_ready are high only while the unit is idle; a pending
//   config beat takes precedence over a sample.
// Sequence:
//   After an input beat the median search tests one candidate per cycle,
//   then the unit updates the running sum, loads the divider, runs the
//   bit-serial divide by the average length and registers the result. A
//   new sample is taken only once the unit is back in idle, so it does not
//   accept a sample before the previous one is through.
// Reset and stalls:
//   Reset loads lengths 5 and 4, start value 25.0 and fills both windows.
//   A finished result waits in the output register; while the previous one
//   is still not taken the unit holds its result and stays busy.
// ----------------------------------------------------------------------------
`include "median_then_moving_average_unit_assert.svh"

module median_then_moving_average_unit (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  mtma_pkg::sample_t                  sample,
	output logic                               out_valid,
	input  logic                               out_ready,
	output mtma_pkg::sample_t                  smoothed,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [mtma_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [mtma_pkg::SAMPLE_W-1:0]      cfg_data
);
	import mtma_pkg::*;

	state_t state_q, state_nxt;

	len_t    med_len_q, avg_len_q;
	sample_t start_q;
	sample_t med_win_q [MED_DEPTH];
	sample_t avg_win_q [AVG_DEPTH];
	logic [MIDX_W-1:0] med_wpos_q;
	logic [AIDX_W-1:0] avg_wpos_q;
	sum_t    sum_q;

	logic [MIDX_W-1:0] cand_q;
	sample_t           median_q;
	logic [SUM_W-1:0]  quo_q;
	len_t              rem_q;
	logic [DCNT_W-1:0] dcnt_q;
	logic              neg_q;

	logic    out_valid_q;
	sample_t smoothed_q;

	len_t n_len, a_len, half;
	logic in_fire, cfg_fire, out_load;
	logic [MIDX_W-1:0] med_wpos_c, med_wpos_inc;
	logic [AIDX_W-1:0] avg_wpos_c, avg_wpos_inc;
	sample_t cand_val;
	logic [CNT_W-1:0] cnt_lt, cnt_le;
	logic med_hit;
	sum_t sum_nxt;
	logic [LEN_W:0] trial;
	logic div_ge, div_last;
	logic [SUM_W-1:0] quo_signed;
	len_t cfg_len;

	assign n_len   = eff_med_len(med_len_q);
	assign a_len   = eff_avg_len(avg_len_q);
	assign half    = n_len >> 1;
	assign cfg_len = cfg_data[LEN_W-1:0];

	assign in_fire  = in_valid && in_ready;
	assign cfg_fire = cfg_valid && cfg_ready;

	// positions clamp to the current lengths before use
	assign med_wpos_c   = (LEN_W'(med_wpos_q) >= n_len) ? '0 : med_wpos_q;
	assign med_wpos_inc = (LEN_W'(med_wpos_c) + LEN_W'(1) == n_len) ? '0
		: med_wpos_c + MIDX_W'(1);
	assign avg_wpos_c   = (LEN_W'(avg_wpos_q) >= a_len) ? '0 : avg_wpos_q;
	assign avg_wpos_inc = (LEN_W'(avg_wpos_q) + LEN_W'(1) == a_len) ? '0
		: avg_wpos_q + AIDX_W'(1);

	// rank test of one candidate against the occupied window
	assign cand_val = med_win_q[cand_q];
	always_comb begin
		cnt_lt = '0;
		cnt_le = '0;
		for (int j = 0; j < MED_DEPTH; j++) begin
			if (j < int'(n_len)) begin
				if (med_win_q[j] < cand_val)  cnt_lt = cnt_lt + CNT_W'(1);
				if (med_win_q[j] <= cand_val) cnt_le = cnt_le + CNT_W'(1);
			end
		end
	end
	assign med_hit = (CNT_W'(half) >= cnt_lt) && (CNT_W'(half) < cnt_le);

	assign sum_nxt = sum_q - sum_t'(SUM_W'(avg_win_q[avg_wpos_q])) + sum_t'(SUM_W'(median_q));

	// restoring divide, one quotient bit per cycle
	assign trial    = {rem_q, quo_q[SUM_W-1]};
	assign div_ge   = trial >= {1'b0, a_len};
	assign div_last = dcnt_q == DCNT_W'(SUM_W - 1);
	assign quo_signed = neg_q ? (~quo_q + SUM_W'(1)) : quo_q;

	// next state
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_IDLE:   if (in_valid && !cfg_valid) state_nxt = ST_MEDIAN;
			ST_MEDIAN: if (med_hit) state_nxt = ST_UPDATE;
			ST_UPDATE: state_nxt = ST_LOAD;
			ST_LOAD:   state_nxt = ST_DIVIDE;
			ST_DIVIDE: if (div_last) state_nxt = ST_FINISH;
			ST_FINISH: if (!out_valid_q || out_ready) state_nxt = ST_IDLE;
			default:   state_nxt = ST_IDLE;
		endcase
	end

	// outputs of the sequencer
	always_comb begin
		in_ready  = 1'b0;
		cfg_ready = 1'b0;
		out_load  = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				cfg_ready = 1'b1;
				in_ready  = !cfg_valid;
			end
			ST_FINISH: out_load = !out_valid_q || out_ready;
			default: begin
				in_ready  = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (out_load)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	// registers, windows and running sum
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			med_len_q  <= RST_MED_LEN;
			avg_len_q  <= RST_AVG_LEN;
			start_q    <= RST_START;
			med_wpos_q <= '0;
			avg_wpos_q <= '0;
			sum_q      <= RST_SUM;
			for (int i = 0; i < MED_DEPTH; i++) med_win_q[i] <= RST_START;
			for (int i = 0; i < AVG_DEPTH; i++) avg_win_q[i] <= RST_START;
		end else begin
			if (cfg_fire) begin
				unique case (cfg_index)
					REG_MED_LEN, REG_AVG_LEN: begin
						if (cfg_index == REG_MED_LEN) begin
							med_len_q <= cfg_len;
							sum_q     <= start_sum(start_q, a_len);
						end else begin
							avg_len_q <= cfg_len;
							sum_q     <= start_sum(start_q, eff_avg_len(cfg_len));
						end
						med_wpos_q <= '0;
						avg_wpos_q <= '0;
						for (int i = 0; i < MED_DEPTH; i++) med_win_q[i] <= start_q;
						for (int i = 0; i < AVG_DEPTH; i++) avg_win_q[i] <= start_q;
					end
					REG_START: start_q <= cfg_data;
					default: start_q <= start_q;  // no such register
				endcase
			end
			if (in_fire) begin
				med_win_q[med_wpos_c] <= sample;
				med_wpos_q <= med_wpos_inc;
				avg_wpos_q <= avg_wpos_c;
			end
			if (state_q == ST_UPDATE) begin
				sum_q <= sum_nxt;
				avg_win_q[avg_wpos_q] <= median_q;
				avg_wpos_q <= avg_wpos_inc;
			end
		end
	end

	// datapath of the shared unit
	always_ff @(posedge clk) begin
		if (in_fire)
			cand_q <= '0;
		else if (state_q == ST_MEDIAN && !med_hit)
			cand_q <= cand_q + MIDX_W'(1);
		if (state_q == ST_MEDIAN && med_hit)
			median_q <= cand_val;
		if (state_q == ST_LOAD) begin
			neg_q  <= sum_q[SUM_W-1];
			quo_q  <= sum_q[SUM_W-1] ? (~sum_q + SUM_W'(1)) : sum_q;
			rem_q  <= '0;
			dcnt_q <= '0;
		end else if (state_q == ST_DIVIDE) begin
			quo_q  <= {quo_q[SUM_W-2:0], div_ge};
			rem_q  <= div_ge ? LEN_W'(trial - {1'b0, a_len}) : LEN_W'(trial);
			dcnt_q <= dcnt_q + DCNT_W'(1);
		end
		if (out_load)
			smoothed_q <= quo_signed[SAMPLE_W-1:0];
	end

	assign out_valid = out_valid_q;
	assign smoothed  = smoothed_q;

	`MTMA_ASSERT_NXT(a_start_search, clk, arst_n, in_fire, state_q == ST_MEDIAN)
	`MTMA_ASSERT_IMP(a_cand_range, clk, arst_n, state_q == ST_MEDIAN, LEN_W'(cand_q) < n_len)
	`MTMA_ASSERT_IMP(a_wpos_range, clk, arst_n, state_q == ST_IDLE,
		(LEN_W'(med_wpos_q) < n_len) && (LEN_W'(avg_wpos_q) < a_len))
	`MTMA_ASSERT_IMP(a_rem_range, clk, arst_n, state_q == ST_DIVIDE, rem_q < a_len)
	`MTMA_ASSERT_NXT(a_hold_result, clk, arst_n,
		state_q == ST_FINISH && out_valid_q && !out_ready, state_q == ST_FINISH && out_valid_q)

endmodule
